// ----- rtl/core/tnwc_pkg.sv -----
// ----------------------------------------------------------------------------
// tnwc_pkg
// Shared types, codes and helpers for the newreno window control block.
// ----------------------------------------------------------------------------
package tnwc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned MssW   = 16;
  localparam int unsigned AckedW = 16;
  localparam int unsigned DupsW  = 8;
  localparam int unsigned CntW   = 5;   // divide step counter, WordW steps

  localparam logic [MssW-1:0]  MssReset     = 16'd1448;
  localparam logic [WordW-1:0] InitWinReset = 32'd14480;
  localparam logic [WordW-1:0] InitThrReset = 32'hFFFF_FFFF;

  // event codes
  typedef enum logic [2:0] {
    OP_ACK_OPEN  = 3'd0,
    OP_ENTER_REC = 3'd1,
    OP_DUP_ACK   = 3'd2,
    OP_EXIT_REC  = 3'd3,
    OP_RESTART   = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MSS      = 2'd0,
    CFG_INIT_WIN = 2'd1,
    CFG_INIT_THR = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CA_CHECK,
    ST_DIV,
    ST_CA_ADD,
    ST_REC_MUL,
    ST_REC_INFL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic ss_step;
    logic sq_load;
    logic div_step;
    logic ca_add;
    logic rec_thr;
    logic rec_prod;
    logic rec_infl;
    logic dup_step;
    logic exit_step;
    logic restart;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic ca_cond;
    logic div_last;
  } status_t;

  function automatic logic [WordW-1:0] sat_add(input logic [WordW-1:0] a,
                                               input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW] ? {WordW{1'b1}} : s[WordW-1:0];
  endfunction

endpackage

// ----- rtl/core/tnwc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tnwc_ctrl
// Sequencer for one event at a time and the output handshake.
// ----------------------------------------------------------------------------
module tnwc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  tnwc_pkg::status_t  status,
  output tnwc_pkg::cmd_t     cmd
);

  tnwc_pkg::state_t state;
  tnwc_pkg::state_t state_next;
  logic             out_valid;
  logic             out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == tnwc_pkg::ST_IDLE);
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tnwc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tnwc_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tnwc_pkg::ST_DISPATCH;
      end
      tnwc_pkg::ST_DISPATCH: begin
        unique case (status.opcode)
          tnwc_pkg::OP_ACK_OPEN:  state_next = tnwc_pkg::ST_CA_CHECK;
          tnwc_pkg::OP_ENTER_REC: state_next = tnwc_pkg::ST_REC_MUL;
          default:                state_next = tnwc_pkg::ST_FINISH;
        endcase
      end
      tnwc_pkg::ST_CA_CHECK: begin
        state_next = status.ca_cond ? tnwc_pkg::ST_DIV : tnwc_pkg::ST_FINISH;
      end
      tnwc_pkg::ST_DIV: begin
        if (status.div_last) state_next = tnwc_pkg::ST_CA_ADD;
      end
      tnwc_pkg::ST_CA_ADD:   state_next = tnwc_pkg::ST_FINISH;
      tnwc_pkg::ST_REC_MUL:  state_next = tnwc_pkg::ST_REC_INFL;
      tnwc_pkg::ST_REC_INFL: state_next = tnwc_pkg::ST_FINISH;
      tnwc_pkg::ST_FINISH: begin
        if (out_free) state_next = tnwc_pkg::ST_IDLE;
      end
      default: state_next = tnwc_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state)
      tnwc_pkg::ST_IDLE:     cmd.load_item = s_tvalid;
      tnwc_pkg::ST_DISPATCH: begin
        unique case (status.opcode)
          tnwc_pkg::OP_ACK_OPEN:  cmd.ss_step   = 1'b1;
          tnwc_pkg::OP_ENTER_REC: cmd.rec_thr   = 1'b1;
          tnwc_pkg::OP_DUP_ACK:   cmd.dup_step  = 1'b1;
          tnwc_pkg::OP_EXIT_REC:  cmd.exit_step = 1'b1;
          tnwc_pkg::OP_RESTART:   cmd.restart   = 1'b1;
          default: ;
        endcase
      end
      tnwc_pkg::ST_CA_CHECK: cmd.sq_load  = status.ca_cond;
      tnwc_pkg::ST_DIV:      cmd.div_step = 1'b1;
      tnwc_pkg::ST_CA_ADD:   cmd.ca_add   = 1'b1;
      tnwc_pkg::ST_REC_MUL:  cmd.rec_prod = 1'b1;
      tnwc_pkg::ST_REC_INFL: cmd.rec_infl = 1'b1;
      tnwc_pkg::ST_FINISH:   cmd.out_load = out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("result register overwritten before transfer");

  // an accepted event is decoded in the following cycle
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == tnwc_pkg::ST_DISPATCH))
    else $error("accepted event not dispatched");

  // loading a result always raises the output valid
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result loaded without valid");

  // divide only runs after the congestion avoidance check
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == tnwc_pkg::ST_DIV) |-> $past(state == tnwc_pkg::ST_CA_CHECK))
    else $error("divide entered from wrong state");
`endif

endmodule

// ----- rtl/core/tnwc_dp.sv -----
// ----------------------------------------------------------------------------
// tnwc_dp
// Window registers, configuration, restoring divider and result register.
// ----------------------------------------------------------------------------
module tnwc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tnwc_pkg::cmd_t                cmd,
  output tnwc_pkg::status_t             status,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tnwc_pkg::WordW-1:0]    cfg_data,
  input  logic [2:0]                    opcode,
  input  logic [tnwc_pkg::AckedW-1:0]   segments_acked,
  input  logic [tnwc_pkg::DupsW-1:0]    dup_ack_count,
  input  logic [tnwc_pkg::WordW-1:0]    bytes_in_flight,
  output logic [tnwc_pkg::WordW-1:0]    window,
  output logic [tnwc_pkg::WordW-1:0]    threshold,
  output logic [tnwc_pkg::WordW-1:0]    inflated_window,
  output logic                          in_slow_start
);

  localparam int unsigned W = tnwc_pkg::WordW;

  // configuration
  logic [tnwc_pkg::MssW-1:0] mss;
  logic [W-1:0]              init_win;
  logic [W-1:0]              init_thr;

  // window state
  logic [W-1:0] cwnd;
  logic [W-1:0] ssth;
  logic [W-1:0] infl;

  // per event working registers
  tnwc_pkg::op_t               op;
  logic [tnwc_pkg::AckedW-1:0] acked;
  logic [tnwc_pkg::DupsW-1:0]  dups;
  logic [W-1:0]                inflight;
  logic [W-1:0]                den;
  logic [W-1:0]                quo;
  logic [W-1:0]                rem;
  logic [tnwc_pkg::CntW-1:0]   cnt;
  logic [tnwc_pkg::DupsW+tnwc_pkg::MssW-1:0] prod;

  logic [W:0]     rem_sh;
  logic [W+1:0]   trial;
  logic [W-1:0]   two_seg;
  logic [W-1:0]   half;
  logic [W-1:0]   thr_new;
  logic [W-1:0]   ca_inc;

  assign rem_sh  = {rem, quo[W-1]};
  assign trial   = {1'b0, rem_sh} - {2'b00, den};
  assign two_seg = {{(W-tnwc_pkg::MssW-1){1'b0}}, mss, 1'b0};
  assign half    = {1'b0, inflight[W-1:1]};
  assign thr_new = (two_seg > half) ? two_seg : half;
  assign ca_inc  = (quo == '0) ? {{(W-1){1'b0}}, 1'b1} : quo;

  assign status.opcode   = op;
  assign status.ca_cond  = (cwnd >= ssth) && (acked != '0);
  assign status.div_last = (cnt == {tnwc_pkg::CntW{1'b1}});

  // configuration and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      mss      <= tnwc_pkg::MssReset;
      init_win <= tnwc_pkg::InitWinReset;
      init_thr <= tnwc_pkg::InitThrReset;
      cwnd     <= tnwc_pkg::InitWinReset;
      ssth     <= tnwc_pkg::InitThrReset;
      infl     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (tnwc_pkg::cfg_idx_t'(cfg_index))
          tnwc_pkg::CFG_MSS:      mss      <= cfg_data[tnwc_pkg::MssW-1:0];
          tnwc_pkg::CFG_INIT_WIN: init_win <= cfg_data;
          tnwc_pkg::CFG_INIT_THR: init_thr <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.ss_step && (cwnd < ssth) && (acked != '0)) begin
        cwnd <= tnwc_pkg::sat_add(cwnd, {{(W-tnwc_pkg::MssW){1'b0}}, mss});
      end
      if (cmd.ca_add) begin
        cwnd <= tnwc_pkg::sat_add(cwnd, ca_inc);
      end
      if (cmd.rec_thr) begin
        ssth <= thr_new;
        cwnd <= thr_new;
      end
      if (cmd.rec_infl) begin
        infl <= tnwc_pkg::sat_add(ssth, {{(W-$bits(prod)){1'b0}}, prod});
      end
      if (cmd.dup_step) begin
        infl <= tnwc_pkg::sat_add(infl, {{(W-tnwc_pkg::MssW){1'b0}}, mss});
      end
      if (cmd.exit_step) begin
        infl <= ssth;
      end
      if (cmd.restart) begin
        cwnd <= init_win;
        ssth <= init_thr;
        infl <= '0;
      end
    end
  end

  // working registers and divider
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op       <= tnwc_pkg::op_t'(opcode);
      acked    <= segments_acked;
      dups     <= dup_ack_count;
      inflight <= bytes_in_flight;
    end
    if (cmd.ss_step && (cwnd < ssth) && (acked != '0)) begin
      acked <= acked - 1'b1;
    end
    if (cmd.sq_load) begin
      quo <= {{(W-tnwc_pkg::MssW){1'b0}}, mss} * {{(W-tnwc_pkg::MssW){1'b0}}, mss};
      rem <= '0;
      den <= (cwnd == '0) ? {{(W-1){1'b0}}, 1'b1} : cwnd;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      if (trial[W+1]) begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end
      cnt <= cnt + 1'b1;
    end
    if (cmd.rec_prod) begin
      prod <= {{tnwc_pkg::MssW{1'b0}}, dups} * {{tnwc_pkg::DupsW{1'b0}}, mss};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      window          <= cwnd;
      threshold       <= ssth;
      inflated_window <= infl;
      in_slow_start   <= (cwnd < ssth);
    end
  end

`ifndef SYNTHESIS
  // remainder stays below the divisor through the divide
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (rem < den))
    else $error("divider remainder out of range");

  // recovery entry leaves window equal to threshold
  a_rec_equal: assert property (@(posedge clk) disable iff (rst)
    cmd.rec_thr |=> (cwnd == ssth))
    else $error("recovery entry window mismatch");

  // restart clears the inflated window
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.restart |=> (infl == '0))
    else $error("restart left inflated window set");
`endif

endmodule

// ----- rtl/core/tcp_newreno_window_control_top.sv -----
// ----------------------------------------------------------------------------
// tcp_newreno_window_control_top
// NewReno congestion window, threshold and inflated window per event.
// ----------------------------------------------------------------------------
// usage
//   events come in on the s_ stream: the opcode in s_tuser, the event
//   fields in s_tdata. every accepted event gives exactly one result
//   transfer on the m_ stream holding the state after the event.
//   the cfg channel writes segment size, initial window and initial
//   threshold; it is always ready and should only be used while idle.
// sequence
//   one event is worked on at a time. dup ack, exit, restart and unused
//   opcodes go from dispatch to finish; recovery entry adds the multiply
//   and inflate states, an open ack the avoidance check, and one that
//   reaches congestion avoidance the 32-step restoring divide of mss
//   squared by the window (one quotient bit a cycle) and the add. a new
//   event is taken in the cycle after the result register is loaded.
// reset
//   rst (synchronous) loads the configuration reset values, window 14480,
//   threshold 2^32-1, inflated window zero, and empties the result.
// stalls
//   a result waits in the output register while m_tready is low; the next
//   event is still taken and worked on, and holds at its end until the
//   waiting result has been transferred.
// ----------------------------------------------------------------------------
module tcp_newreno_window_control_top (
  input  logic          clk,
  input  logic          rst,
  // event input
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [55:0]   s_tdata,   // segments_acked[15:0], dup_ack_count[23:16],
                                   // bytes_in_flight[55:24]
  input  logic [2:0]    s_tuser,   // opcode[2:0]
  // result output
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // window[31:0], threshold[63:32],
                                   // inflated_window[95:64], in_slow_start[96],
                                   // zero[103:97]
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  tnwc_pkg::cmd_t    cmd;
  tnwc_pkg::status_t status;

  logic [31:0] window;
  logic [31:0] threshold;
  logic [31:0] inflated_window;
  logic        in_slow_start;

  // configuration is taken every cycle
  assign cfg_ready = 1'b1;

  assign m_tdata = {7'd0, in_slow_start, inflated_window, threshold, window};

  tnwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tnwc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .opcode          (s_tuser),
    .segments_acked  (s_tdata[15:0]),
    .dup_ack_count   (s_tdata[23:16]),
    .bytes_in_flight (s_tdata[55:24]),
    .window          (window),
    .threshold       (threshold),
    .inflated_window (inflated_window),
    .in_slow_start   (in_slow_start)
  );

endmodule

// ----- bench/tcp_newreno_window_control_checker.sv -----
// ----------------------------------------------------------------------------
// tcp_newreno_window_control_checker
// Follows the window state from observed transfers and checks every result.
// ----------------------------------------------------------------------------
module tcp_newreno_window_control_checker
  import tnwc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [55:0]  s_tdata,   // segments_acked[15:0], dup_ack_count[23:16],
                                  // bytes_in_flight[55:24]
  input  logic [2:0]   s_tuser,   // opcode[2:0]
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,   // window[31:0], threshold[63:32],
                                  // inflated_window[95:64], in_slow_start[96]
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int unsigned  errors,
  output int unsigned  outstanding,
  output int unsigned  results_seen,
  output int unsigned  ca_steps
);

  typedef struct packed {
    logic [WordW-1:0] window;
    logic [WordW-1:0] threshold;
    logic [WordW-1:0] inflated;
    logic             slow_start;
  } window_report_t;

  logic [MssW-1:0]  mss;
  logic [WordW-1:0] init_window;
  logic [WordW-1:0] init_threshold;
  logic [WordW-1:0] cwnd;
  logic [WordW-1:0] ssthresh;
  logic [WordW-1:0] infl;

  window_report_t expected_reports[$];

  function automatic logic [WordW-1:0] clamp_sum(input logic [WordW-1:0] a,
                                                 input logic [63:0] b);
    logic [64:0] total;
    total = {33'd0, a} + {1'b0, b};
    return (total > 65'h0_FFFF_FFFF) ? '1 : total[WordW-1:0];
  endfunction

  // slow start adds at most one segment, leftover acks give one avoidance step
  function automatic void grow_window(input logic [AckedW-1:0] acked);
    logic [AckedW-1:0] left;
    logic [63:0]       square;
    logic [63:0]       divisor;
    logic [63:0]       step;
    left = acked;
    if (cwnd < ssthresh && left != 0) begin
      cwnd = clamp_sum(cwnd, {48'd0, mss});
      left = left - 1'b1;
    end
    if (cwnd >= ssthresh && left != 0) begin
      square  = {48'd0, mss} * {48'd0, mss};
      divisor = (cwnd == 0) ? 64'd1 : {32'd0, cwnd};
      step    = square / divisor;
      if (step == 0) step = 64'd1;
      cwnd = clamp_sum(cwnd, step);
      ca_steps++;
    end
  endfunction

  function automatic void apply_event(input logic [2:0] code, input logic [55:0] fields);
    logic [WordW-1:0] two_segments;
    logic [WordW-1:0] half_flight;
    two_segments = {15'd0, mss, 1'b0};
    half_flight  = fields[55:24] >> 1;
    case (code)
      OP_ACK_OPEN:  grow_window(fields[15:0]);
      OP_ENTER_REC: begin
        ssthresh = (two_segments > half_flight) ? two_segments : half_flight;
        cwnd     = ssthresh;
        infl     = clamp_sum(ssthresh, {56'd0, fields[23:16]} * {48'd0, mss});
      end
      OP_DUP_ACK:   infl = clamp_sum(infl, {48'd0, mss});
      OP_EXIT_REC:  infl = ssthresh;
      OP_RESTART: begin
        cwnd     = init_window;
        ssthresh = init_threshold;
        infl     = '0;
      end
      default: ;   // spare opcodes leave the state alone
    endcase
  endfunction

  function automatic void check_field(input string label, input logic [WordW-1:0] want,
                                      input logic [WordW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    window_report_t want;
    if (rst) begin
      mss            = MssReset;
      init_window    = InitWinReset;
      init_threshold = InitThrReset;
      cwnd           = InitWinReset;
      ssthresh       = InitThrReset;
      infl           = '0;
      errors         = 0;
      results_seen   = 0;
      ca_steps       = 0;
      expected_reports.delete();
      outstanding   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MSS:      mss            = cfg_data[MssW-1:0];
          CFG_INIT_WIN: init_window    = cfg_data;
          CFG_INIT_THR: init_threshold = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        apply_event(s_tuser, s_tdata);
        expected_reports.push_back('{cwnd, ssthresh, infl, cwnd < ssthresh});
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: result 0x%026h with no event waiting, expected none",
                   $time, m_tdata);
        end else begin
          want = expected_reports.pop_front();
          check_field("window", want.window, m_tdata[31:0]);
          check_field("threshold", want.threshold, m_tdata[63:32]);
          check_field("inflated window", want.inflated, m_tdata[95:64]);
          check_field("slow start flag", {31'd0, want.slow_start}, {31'd0, m_tdata[96]});
          check_field("padding", '0, {25'd0, m_tdata[103:97]});
        end
      end
      outstanding <= expected_reports.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives events and register writes into the newreno window block, with
// random gaps and back-pressure; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import tnwc_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles without any transfer
  localparam int unsigned SETTLE_CYCLES = 40;    // longer than the longest event
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_EVENTS  = 250;
  localparam int unsigned STEADY_PHASE  = 3;     // phase run with no idling
  localparam int unsigned IDLE_PERCENT  = 34;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [WordW-1:0] WORD_ALL  = '1;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata   = '0;
  logic [2:0]   s_tuser   = OP_ACK_OPEN;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [103:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = CFG_MSS;
  logic [31:0]  cfg_data  = '0;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned ca_steps;
  int unsigned events_sent   = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles  = 0;
  bit          steady        = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tcp_newreno_window_control_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tcp_newreno_window_control_checker window_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .ca_steps     (ca_steps)
  );

  // result side back-pressure, switched off during the steady phase
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d events sent", $time, QUIET_LIMIT,
                 events_sent);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  // one event transfer, with random idle cycles in front
  task automatic send_event(input logic [2:0] code, input logic [AckedW-1:0] acked,
                            input logic [DupsW-1:0] dups, input logic [WordW-1:0] inflight);
    while (take_gap()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= {inflight, dups, acked};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    events_sent++;
  endtask

  // stop sending and wait until every result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // registers are only touched once the block has gone idle
  task automatic load_settings(input logic [MssW-1:0] mss, input logic [WordW-1:0] win,
                               input logic [WordW-1:0] thr);
    drain_results();
    repeat (4) @(posedge clk);
    write_register(CFG_MSS, {16'd0, mss});
    write_register(CFG_INIT_WIN, win);
    write_register(CFG_INIT_THR, thr);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [WordW-1:0] pick_inflight();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1 << 20);
      2:       return WORD_ALL;
      default: return $urandom_range(0, 1 << 16);
    endcase
  endfunction

  // an ack run, a full recovery episode, or a single stray event
  task automatic random_burst();
    int unsigned      count;
    logic [AckedW-1:0] acked;
    logic [DupsW-1:0]  dups;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        count = $urandom_range(1, 12);
        repeat (count) begin
          case ($urandom_range(0, 9))
            7, 8:    acked = AckedW'($urandom);
            9:       acked = '1;
            default: acked = AckedW'($urandom_range(0, 4));
          endcase
          send_event(OP_ACK_OPEN, acked, DupsW'($urandom), $urandom);
        end
      end
      5, 6, 7: begin
        dups = DupsW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8));
        send_event(OP_ENTER_REC, AckedW'($urandom), dups, pick_inflight());
        count = $urandom_range(0, 6);
        repeat (count) send_event(OP_DUP_ACK, AckedW'($urandom), DupsW'($urandom), $urandom);
        send_event(OP_EXIT_REC, AckedW'($urandom), DupsW'($urandom), $urandom);
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       send_event(OP_RESTART, AckedW'($urandom), DupsW'($urandom), $urandom);
          1:       send_event(OP_DUP_ACK, AckedW'($urandom), DupsW'($urandom), $urandom);
          2:       send_event(OP_EXIT_REC, AckedW'($urandom), DupsW'($urandom), $urandom);
          3:       send_event(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                              AckedW'($urandom), DupsW'($urandom), $urandom);
          default: send_event(OP_ENTER_REC, AckedW'($urandom), DupsW'($urandom),
                              pick_inflight());
        endcase
      end
    endcase
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      phase_start;
    logic [MssW-1:0]  mss_pick;
    logic [WordW-1:0] win_pick;
    logic [WordW-1:0] thr_pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: slow start, no acks, leftover acks, recovery at both extremes
    send_event(OP_ACK_OPEN, 16'd1, '0, '0);
    send_event(OP_ACK_OPEN, 16'd0, '1, '1);
    send_event(OP_ACK_OPEN, '1, '0, '0);
    send_event(OP_ENTER_REC, '0, 8'd0, 32'd0);
    send_event(OP_DUP_ACK, '0, '0, '0);
    send_event(OP_EXIT_REC, '0, '0, '0);
    send_event(OP_ACK_OPEN, 16'd1, '0, '0);
    send_event(OP_ACK_OPEN, 16'd2, '0, '0);
    send_event(OP_ENTER_REC, '1, '1, '1);
    send_event(OP_DUP_ACK, '1, '1, '1);
    send_event(OP_EXIT_REC, '1, '1, '1);
    for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++) begin
      send_event(code[2:0], '1, '1, '1);
    end
    send_event(OP_RESTART, '1, '1, '1);

    // widest segment and full-scale initial values: sums saturate
    load_settings('1, WORD_ALL, WORD_ALL);
    send_event(OP_RESTART, '0, '0, '0);
    send_event(OP_ACK_OPEN, 16'd1, '0, '0);
    send_event(OP_EXIT_REC, '0, '0, '0);
    send_event(OP_DUP_ACK, '0, '0, '0);

    // zero segment and zero window: the divide sees a window of zero
    load_settings('0, '0, '0);
    send_event(OP_RESTART, '0, '0, '0);
    send_event(OP_ACK_OPEN, 16'd1, '0, '0);
    send_event(OP_ENTER_REC, '0, '1, 32'd1);
    send_event(OP_DUP_ACK, '0, '0, '0);

    // smallest legal values: one slow start step then one avoidance step
    load_settings(16'd1, 32'd1, 32'd2);
    send_event(OP_RESTART, '0, '0, '0);
    send_event(OP_ACK_OPEN, 16'd5, '0, '0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 6))
        0:       mss_pick = 16'd1;
        1:       mss_pick = '1;
        2:       mss_pick = 16'd536;
        3:       mss_pick = MssReset;
        4:       mss_pick = '0;
        default: mss_pick = MssW'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       win_pick = {16'd0, mss_pick} * $urandom_range(1, 20);
        1:       win_pick = $urandom;
        2:       win_pick = WORD_ALL;
        default: win_pick = $urandom_range(1, 4);
      endcase
      // in two cases of five a threshold a little above the window so both regimes are reached
      case ($urandom_range(0, 4))
        0:       thr_pick = WORD_ALL;
        1:       thr_pick = $urandom;
        2:       thr_pick = $urandom_range(0, 1 << 17);
        default: thr_pick = win_pick + {16'd0, mss_pick} * $urandom_range(0, 40);
      endcase
      load_settings(mss_pick, win_pick, thr_pick);
      steady = (phase == STEADY_PHASE);
      phase_start = events_sent;
      send_event(OP_RESTART, AckedW'($urandom), DupsW'($urandom), $urandom);
      while (events_sent < phase_start + PHASE_EVENTS) random_burst();
    end
    steady = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d events over %0d register settings, %0d results compared",
             events_sent, settings_used, results_seen);
    $display("of those, %0d acks reached congestion avoidance", ca_steps);
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tnwc_pkg.sv
rtl/core/tnwc_ctrl.sv
rtl/core/tnwc_dp.sv
rtl/core/tcp_newreno_window_control_top.sv
bench/tcp_newreno_window_control_checker.sv
bench/testbench.sv
